/* rtl/rau_pkg.sv */
// Package for the rational arithmetic unit: operation codes, status codes
// and the descriptor passed from the front end to the back end. No dependencies.
`default_nettype none
package rau_pkg;
    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_CMP = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // classified word: either a finished result or a gcd job
    typedef struct packed {
        logic        run;
        logic        neg;
        logic [63:0] nmag;
        logic [63:0] dmag;
        logic        lt;
        logic        eq;
        logic [1:0]  status;
    } job_t;
endpackage
`default_nettype wire

/* rtl/rau_front.sv */
// Front end: sign extends operands, forms cross products in F_MUL1, F_MUL2
// and classifies the word into a finished result or a gcd job. Uses rau_pkg.
`default_nettype none
module rau_front import rau_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_mode,
    input  wire  [31:0] s_a_num,
    input  wire  [30:0] s_a_den,
    input  wire  [31:0] s_b_num,
    input  wire  [30:0] s_b_den,
    output logic        job_valid,
    input  wire         job_ready,
    output job_t        job
);
    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_MUL1 = 3'd1;
    localparam logic [2:0] F_MUL2 = 3'd2;
    localparam logic [2:0] F_CLS  = 3'd3;
    localparam logic [2:0] F_OUT  = 3'd4;

    logic [2:0] st_reg, st_next;
    logic [2:0] mode_reg;
    logic signed [32:0] an_reg, bn_reg, ad_reg, bd_reg;
    logic signed [65:0] p_reg, q_reg, r_reg, s_reg;
    logic signed [32:0] m1a, m1b, m2a, m2b;
    logic signed [65:0] m1, m2;
    job_t job_reg, cls;
    logic signed [65:0] num;
    logic lt, eq;

    function automatic logic signed [32:0] sxn(input logic [31:0] x);
        logic [31:0] v;
        v = x << (32 - VALUE_WIDTH);
        return 33'(signed'(v) >>> (32 - VALUE_WIDTH));
    endfunction

    function automatic logic [63:0] mag(input logic signed [65:0] v);
        logic [65:0] u;
        u = v[65] ? 66'(-v) : 66'(v);
        return u[63:0];
    endfunction

    localparam logic [30:0] DMASK = 31'((64'd1 << (VALUE_WIDTH - 1)) - 64'd1);

    always_comb begin
        m1a = an_reg; m1b = bd_reg; m2a = bn_reg; m2b = ad_reg;
        if (st_reg == F_MUL2) begin
            m1a = ad_reg; m1b = bd_reg; m2a = an_reg; m2b = bn_reg;
        end
    end
    assign m1 = m1a * m1b;
    assign m2 = m2a * m2b;
    assign s_ready = (st_reg == F_IDLE);
    assign job_valid = (st_reg == F_OUT);
    assign job = job_reg;

    always_comb begin
        lt = p_reg < q_reg;
        eq = p_reg == q_reg;
        cls = '0;
        cls.lt = lt;
        cls.eq = eq;
        cls.status = ST_OK;
        num = '0;
        cls.dmag = r_reg[63:0];
        if (ad_reg == 0 || bd_reg == 0) begin
            cls.lt = 1'b0;
            cls.eq = 1'b0;
            cls.status = ST_DIVZ;
        end else begin
            case (mode_reg)
                MODE_ADD: num = p_reg + q_reg;
                MODE_SUB: num = p_reg - q_reg;
                MODE_MUL: num = s_reg;
                MODE_DIV: num = p_reg;
                default:  num = '0;
            endcase
            cls.nmag = mag(num);
            cls.neg = num[65];
            if (mode_reg == MODE_DIV) begin
                // ad*bn equals q
                cls.dmag = mag(q_reg);
                cls.neg = num[65] ^ q_reg[65];
                if (bn_reg == 0)
                    cls.status = ST_DIVZ;
            end
            cls.run = (mode_reg <= MODE_DIV) && (cls.status == ST_OK) && (num != 0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= F_IDLE;
        end else begin
            st_reg <= st_next;
        end
        case (st_reg)
            F_IDLE: begin
                mode_reg <= s_mode;
                an_reg <= sxn(s_a_num);
                bn_reg <= sxn(s_b_num);
                ad_reg <= 33'(s_a_den & DMASK);
                bd_reg <= 33'(s_b_den & DMASK);
            end
            F_MUL1: begin
                p_reg <= m1;
                q_reg <= m2;
            end
            F_MUL2: begin
                r_reg <= m1;
                s_reg <= m2;
            end
            F_CLS: job_reg <= cls;
            default: ;
        endcase
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE: if (s_valid) st_next = F_MUL1;
            F_MUL1: st_next = F_MUL2;
            F_MUL2: st_next = F_CLS;
            F_CLS:  st_next = F_OUT;
            F_OUT:  if (job_ready) st_next = F_IDLE;
            default: st_next = F_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/rau_queue.sv */
// Two-entry queue of job words between front and back end. Uses rau_pkg.
`default_nettype none
module rau_queue import rau_pkg::*; (
    input  wire   aclk,
    input  wire   aresetn,
    input  wire   in_valid,
    output logic  in_ready,
    input  job_t  in_word,
    output logic  out_valid,
    input  wire   out_ready,
    output job_t  out_word
);
    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_word = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= ~wp_reg;
            if (pop) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(push) - 2'(pop);
        end
        if (push) mem_reg[wp_reg] <= in_word;
    end
endmodule
`default_nettype wire

/* rtl/rau_back.sv */
// Back end: binary gcd over 64-bit magnitudes, one step a cycle, then
// exact division by a restoring divider, range check and output register.
// Uses rau_pkg.
`default_nettype none
module rau_back import rau_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          job_valid,
    output logic         job_ready,
    input  job_t         job,
    output logic         m_valid,
    input  wire          m_ready,
    output logic [31:0]  m_res_num,
    output logic [30:0]  m_res_den,
    output logic         m_less,
    output logic         m_equal,
    output logic [1:0]   m_status
);
    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_GCD  = 3'd1;
    localparam logic [2:0] B_DIVN = 3'd2;
    localparam logic [2:0] B_DIVD = 3'd3;
    localparam logic [2:0] B_CHK  = 3'd4;
    localparam logic [63:0] LIM = 64'd1 << (VALUE_WIDTH - 1);

    logic [2:0] st_reg, st_next;
    job_t j_reg;
    logic [63:0] u_reg, v_reg, g_reg;
    logic [5:0] k_reg;
    logic [63:0] q_reg, rem_reg, dv_reg, nq_reg;
    logic [6:0] i_reg;
    logic [64:0] trial;
    logic [63:0] diff;
    logic out_free;

    assign out_free = !m_valid || m_ready;
    assign job_ready = (st_reg == B_IDLE) && out_free;
    assign trial = {rem_reg, dv_reg[63]} - {1'b0, g_reg};
    assign diff = (u_reg > v_reg) ? u_reg - v_reg : v_reg - u_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= B_IDLE;
            m_valid <= 1'b0;
        end else begin
            st_reg <= st_next;
            if ((st_reg == B_IDLE && job_valid && out_free && !job.run) || st_reg == B_CHK)
                m_valid <= 1'b1;
            else if (m_valid && m_ready)
                m_valid <= 1'b0;
        end
        case (st_reg)
            B_IDLE: begin
                j_reg <= job;
                u_reg <= job.nmag;
                v_reg <= job.dmag;
                k_reg <= '0;
                if (job_valid && out_free && !job.run) begin
                    m_res_num <= '0;
                    m_res_den <= 31'd1;
                    m_less <= job.lt;
                    m_equal <= job.eq;
                    m_status <= job.status;
                end
            end
            B_GCD: begin
                // stein step on nonzero u
                if (v_reg == 0) begin
                    g_reg <= u_reg << k_reg;
                    dv_reg <= j_reg.nmag;
                    rem_reg <= '0;
                    i_reg <= '0;
                end else if (!u_reg[0] && !v_reg[0]) begin
                    u_reg <= u_reg >> 1; v_reg <= v_reg >> 1; k_reg <= k_reg + 6'd1;
                end else if (!u_reg[0]) begin
                    u_reg <= u_reg >> 1;
                end else if (!v_reg[0]) begin
                    v_reg <= v_reg >> 1;
                end else begin
                    u_reg <= (u_reg < v_reg) ? u_reg : v_reg;
                    v_reg <= diff >> 1;
                end
            end
            B_DIVN, B_DIVD: begin
                if (i_reg == 7'd63) begin
                    rem_reg <= '0;
                    i_reg <= '0;
                    if (st_reg == B_DIVN) begin
                        nq_reg <= {dv_reg[62:0], ~trial[64]};
                        dv_reg <= j_reg.dmag;
                    end else begin
                        q_reg <= {dv_reg[62:0], ~trial[64]};
                    end
                end else begin
                    dv_reg <= {dv_reg[62:0], ~trial[64]};
                    rem_reg <= trial[64] ? {rem_reg[62:0], dv_reg[63]} : trial[63:0];
                    i_reg <= i_reg + 7'd1;
                end
            end
            B_CHK: begin
                m_less <= j_reg.lt;
                m_equal <= j_reg.eq;
                if (q_reg > LIM - 64'd1 || nq_reg > (j_reg.neg ? LIM : LIM - 64'd1)) begin
                    m_res_num <= '0;
                    m_res_den <= 31'd1;
                    m_status <= ST_OVF;
                end else begin
                    m_res_num <= j_reg.neg ? 32'(-nq_reg) : nq_reg[31:0];
                    m_res_den <= q_reg[30:0];
                    m_status <= ST_OK;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            B_IDLE: if (job_valid && out_free && job.run) st_next = B_GCD;
            B_GCD:  if (v_reg == 0) st_next = B_DIVN;
            B_DIVN: if (i_reg == 7'd63) st_next = B_DIVD;
            B_DIVD: if (i_reg == 7'd63) st_next = B_CHK;
            B_CHK:  st_next = B_IDLE;
            default: st_next = B_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/rational_arithmetic_unit_top.sv */
// Rational arithmetic unit: add, subtract, multiply, divide, compare of two
// 32-bit rationals with gcd reduction.
// Channels: s_* input words (mode and operands), m_* result words, both
// valid/ready; a word moves when valid and ready are high at a clock edge.
// The front end takes a word, forms the 64-bit cross products in two
// multiplier passes and classifies it, then hands it through a
// two-entry queue to the back end.
// Compare, zero-result and error words are registered into the output in the
// cycle they are dequeued. Other words run a binary gcd, one step a cycle,
// then two restoring divisions (numerator, then denominator) on the shared
// divider.
// aresetn (synchronous, active low) empties the queue and both controllers.
// A stalled receiver holds the result register; the queue then fills and the
// front end stops taking words.
`default_nettype none
module rational_arithmetic_unit_top import rau_pkg::*; #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [2:0]  s_mode,
    input  wire  [31:0] s_a_num,
    input  wire  [30:0] s_a_den,
    input  wire  [31:0] s_b_num,
    input  wire  [30:0] s_b_den,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [31:0] m_res_num,
    output logic [30:0] m_res_den,
    output logic        m_less,
    output logic        m_equal,
    output logic [1:0]  m_status
);
    job_t f_word, b_word;
    logic f_valid, f_ready, b_valid, b_ready;

    rau_front #(.VALUE_WIDTH(VALUE_WIDTH)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_a_num, .s_a_den,
        .s_b_num, .s_b_den, .job_valid(f_valid), .job_ready(f_ready), .job(f_word)
    );

    rau_queue u_queue (
        .aclk, .aresetn, .in_valid(f_valid), .in_ready(f_ready), .in_word(f_word),
        .out_valid(b_valid), .out_ready(b_ready), .out_word(b_word)
    );

    rau_back #(.VALUE_WIDTH(VALUE_WIDTH)) u_back (
        .aclk, .aresetn, .job_valid(b_valid), .job_ready(b_ready), .job(b_word),
        .m_valid, .m_ready, .m_res_num, .m_res_den, .m_less, .m_equal, .m_status
    );

`ifndef SYNTHESIS
    a_den_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_res_den != 31'd0) else $error("zero result denominator");
    a_eq_lt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_less && m_equal)) else $error("less and equal both set");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_res_num == 32'd0 && m_res_den == 31'd1))
        else $error("error result not cleared");
`endif
endmodule
`default_nettype wire

/* dv/rau_checker.sv */
// Checker for the rational arithmetic unit: watches both channels, predicts
// each result word from the input word and compares field by field.
// Depends on rau_pkg for operation and status codes.
`timescale 1ns / 100ps
module rau_checker import rau_pkg::*; (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    input  wire         s_ready,
    input  wire  [2:0]  s_mode,
    input  wire  [31:0] s_a_num,
    input  wire  [30:0] s_a_den,
    input  wire  [31:0] s_b_num,
    input  wire  [30:0] s_b_den,
    input  wire         m_valid,
    input  wire         m_ready,
    input  wire  [31:0] m_res_num,
    input  wire  [30:0] m_res_den,
    input  wire         m_less,
    input  wire         m_equal,
    input  wire  [1:0]  m_status,
    output int          fail_count,
    output int          pending,
    output int          result_count
);
    typedef struct packed {
        logic [31:0] num;
        logic [30:0] den;
        logic        lt;
        logic        eq;
        logic [1:0]  st;
    } fraction_t;

    fraction_t reduced_q[$];

    function automatic logic [63:0] euclid_gcd(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return (x == 0) ? 64'd1 : x;
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic fraction_t reduce_fraction(logic [2:0] op, logic [31:0] an_w,
                                                   logic [30:0] ad_w, logic [31:0] bn_w,
                                                   logic [30:0] bd_w);
        fraction_t r;
        longint an, ad, bn, bd, p, q, num;
        logic [63:0] nmag, dmag, g;
        logic nneg, dneg;
        an = longint'(signed'(an_w));
        bn = longint'(signed'(bn_w));
        ad = longint'({33'd0, ad_w});
        bd = longint'({33'd0, bd_w});
        r = '{num: 32'd0, den: 31'd1, lt: 1'b0, eq: 1'b0, st: ST_OK};
        if (ad == 0 || bd == 0) begin
            r.st = ST_DIVZ;
            return r;
        end
        p = an * bd;
        q = bn * ad;
        r.lt = p < q;
        r.eq = p == q;
        dneg = 1'b0;
        dmag = 64'(ad * bd);
        case (op)
            MODE_ADD: num = p + q;
            MODE_SUB: num = p - q;
            MODE_MUL: num = an * bn;
            MODE_DIV: begin
                if (bn == 0) begin
                    r.st = ST_DIVZ;
                    return r;
                end
                num = p;
                dneg = (ad * bn) < 0;
                dmag = magnitude(ad * bn);
            end
            default: return r;
        endcase
        nneg = num < 0;
        nmag = magnitude(num);
        if (nmag == 0) return r;
        nneg = nneg ^ dneg;
        g = euclid_gcd(nmag, dmag);
        nmag = nmag / g;
        dmag = dmag / g;
        if (dmag > 64'h7FFF_FFFF || nmag > (nneg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
            r.st = ST_OVF;
            return r;
        end
        r.num = nneg ? 32'(-nmag) : nmag[31:0];
        r.den = dmag[30:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        fraction_t want;
        if (!aresetn) begin
            fail_count <= 0;
            result_count <= 0;
            pending <= 0;
        end else begin
            if (s_valid && s_ready)
                reduced_q.push_back(reduce_fraction(s_mode, s_a_num, s_a_den,
                                                    s_b_num, s_b_den));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (reduced_q.size() == 0) begin
                    $display("%0t: unexpected word %h/%h", $time, m_res_num, m_res_den);
                    fail_count <= fail_count + 1;
                end else begin
                    want = reduced_q.pop_front();
                    if (want != {m_res_num, m_res_den, m_less, m_equal, m_status}) begin
                        $display("%0t: mismatch expected num %h den %h lt %b eq %b st %0d",
                                 $time, want.num, want.den, want.lt, want.eq, want.st);
                        $display("%0t:          actual   num %h den %h lt %b eq %b st %0d",
                                 $time, m_res_num, m_res_den, m_less, m_equal, m_status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= reduced_q.size();
        end
    end
endmodule

/* dv/testbench.sv */
// Top of the rational arithmetic unit testbench: clock, reset, stimulus with
// random gaps and stalls, and the verdict. Depends on rau_pkg, rau_checker and the top.
`timescale 1ns / 100ps
module testbench import rau_pkg::*;;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_mode = MODE_ADD;
    logic [31:0] s_a_num = '0;
    logic [30:0] s_a_den = 31'd1;
    logic [31:0] s_b_num = '0;
    logic [30:0] s_b_den = 31'd1;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_res_num;
    logic [30:0] m_res_den;
    logic        m_less, m_equal;
    logic [1:0]  m_status;
    int          fail_count, pending, result_count;
    int          rx_wait = 0;

    always #2 aclk = ~aclk;

    rational_arithmetic_unit_top DUT (.*);
    rau_checker checker_inst (.*);

    task automatic send_word(logic [2:0] op, logic [31:0] an, logic [30:0] ad,
                             logic [31:0] bn, logic [30:0] bd);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode <= op;
        s_a_num <= an;
        s_a_den <= ad;
        s_b_num <= bn;
        s_b_den <= bd;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        wait (pending == 0);
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_num(int kind);
        case (kind)
            0: return 32'($signed($urandom_range(0, 40)) - 20);
            1: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2: return 32'($signed($urandom_range(0, 2000)) - 1000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [30:0] rand_den(int kind);
        case (kind)
            0: return 31'($urandom_range(1, 24));
            1: return $urandom_range(0, 1) ? 31'h7FFF_FFFF : 31'd1;
            2: return 31'($urandom_range(0, 20) == 0 ? 0 : $urandom_range(1, 1000));
            default: return 31'($urandom);
        endcase
    endfunction

    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else if (m_valid && m_ready) begin
            w = $urandom_range(0, 16);
            rx_wait <= w;
            m_ready <= (w == 0);
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            rx_wait <= 0;
            m_ready <= 1'b1;
        end
    end

    initial begin
        logic [2:0] op;
        int ka, kb;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int m = 0; m < 8; m++) send_word(3'(m), 32'd3, 31'd4, -32'sd5, 31'd6);
        send_word(MODE_ADD, 32'h7FFF_FFFF, 31'd1, 32'h7FFF_FFFF, 31'd1);
        send_word(MODE_SUB, 32'h8000_0000, 31'd1, 32'h7FFF_FFFF, 31'd1);
        send_word(MODE_MUL, 32'h8000_0000, 31'd1, 32'hFFFF_FFFF, 31'd1);
        send_word(MODE_MUL, 32'h8000_0000, 31'd1, 32'd1, 31'd1);
        send_word(MODE_DIV, 32'd7, 31'd2, 32'd0, 31'd5);
        send_word(MODE_DIV, 32'h8000_0000, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_word(MODE_ADD, 32'd1, 31'd0, 32'd1, 31'd3);
        send_word(MODE_DIV, 32'd1, 31'd3, 32'd1, 31'd0);
        send_word(MODE_SUB, 32'd5, 31'd7, 32'd5, 31'd7);
        send_word(MODE_ADD, 32'd2, 31'd4, 32'd6, 31'd8);
        send_word(MODE_ADD, 32'd1, 31'h7FFF_FFFF, 32'd1, 31'h7FFF_FFFE);
        send_word(MODE_MUL, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_word(MODE_CMP, 32'hFFFF_FFFF, 31'd2, 32'd0, 31'd1);
        send_word(MODE_DIV, 32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555);
        drain_results();
        for (int i = 0; i < 700; i++) begin
            op = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(MODE_CMP, 7))
                                             : 3'($urandom_range(0, 3));
            ka = $urandom_range(0, 3);
            kb = $urandom_range(0, 3);
            send_word(op, rand_num(ka), rand_den(ka), rand_num(kb), rand_den(kb));
            if (i == 350) drain_results();
        end
        drain_results();
        repeat (400) @(posedge aclk);
        $display("Sent %0d words over all five operations, extremes and error cases;",
                 result_count);
        $display("random gaps and stalls on both channels.");
        if (fail_count == 0)
            $display("PASS rational_arithmetic_unit_top");
        else
            $display("FAIL rational_arithmetic_unit_top");
        $finish;
    end

    initial begin
        #6000000;
        $display("FAIL rational_arithmetic_unit_top");
        $finish;
    end
endmodule
